// ===== sv/wfsp_pkg.sv =====
`timescale 1ns / 1ps

package wfsp_pkg;

    localparam int DEF_PROCS       = 8;
    localparam int DEF_WEIGHT_BITS = 8;

    localparam int SLOT_W   = 3;
    localparam int IN_WGT_W = 8;
    localparam int ID_W     = 8;
    localparam int TICK_W   = 16;
    localparam int ACT_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT   = 4'd1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] wdata;
    } cfg_beat_t;

    typedef struct packed {
        cmd_t                command;
        logic [SLOT_W-1:0]   slot;
        logic [IN_WGT_W-1:0] weight;
        logic [ID_W-1:0]     proc_id;
    } req_beat_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] grant_slot;
        logic [ID_W-1:0]   grant_id;
        logic [TICK_W-1:0] tick_time;
        logic              finished;
    } rsp_beat_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== sv/wfsp_chan_if.sv =====
`timescale 1ns / 1ps

interface wfsp_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/wfsp_table.sv =====
`timescale 1ns / 1ps

module wfsp_table #(
    parameter int PROCS = 8,
    parameter int IDX_W = 3,
    parameter int ENT_W = 24
) (
    input  logic              clk,
    input  wfsp_pkg::mem_ctl_t ctl,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [ENT_W-1:0]  wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [ENT_W-1:0]  rdata
);
    import wfsp_pkg::*;

    logic [ENT_W-1:0] ent_mem [PROCS];
    logic [ENT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ent_mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= ent_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wfsp_ctrl.sv =====
`timescale 1ns / 1ps

module wfsp_ctrl #(
    parameter int PROCS       = 8,
    parameter int WEIGHT_BITS = 8,
    parameter int IDX_W       = 3,
    parameter int ENT_W       = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    wfsp_chan_if.sink          cfg,
    wfsp_chan_if.sink          req,
    wfsp_chan_if.source        rsp,
    output wfsp_pkg::mem_ctl_t mem_ctl,
    output logic [IDX_W-1:0]   mem_waddr,
    output logic [ENT_W-1:0]   mem_wdata,
    output logic [IDX_W-1:0]   mem_raddr,
    input  logic [ENT_W-1:0]   mem_rdata
);
    import wfsp_pkg::*;

    localparam int WB     = WEIGHT_BITS;
    localparam int PROD_W = 2 * WEIGHT_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WB   = 4'b0100,
        S_POST = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ACT_W-1:0]    active_count_reg;
    logic [TICK_W-1:0]   time_limit_reg;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [ACT_W-1:0]    completed_reg, completed_next;
    logic [ACT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [ACT_W-1:0]    arr_reg, arr_next;
    logic                found_reg, found_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [WB-1:0]       best_w_reg, best_w_next;
    logic [WB-1:0]       best_r_reg, best_r_next;
    logic [ID_W-1:0]     best_id_reg, best_id_next;
    rsp_beat_t           res_reg, res_next;
    rsp_beat_t           rsp_data_reg, rsp_data_next;

    logic [ACT_W-1:0]    n_eff;
    logic                req_fire;
    logic                is_done;
    logic                slot_ok;
    logic [WB-1:0]       load_w;
    logic [WB-1:0]       c_r, c_w;
    logic [ID_W-1:0]     c_id;
    logic                c_live;
    logic [PROD_W-1:0]   lhs, rhs;
    logic                take;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign n_eff    = (32'(active_count_reg) > PROCS) ? ACT_W'(PROCS) : active_count_reg;
    assign req_fire = req.valid && req.ready;
    assign is_done  = (tick_count_reg >= time_limit_reg) || (completed_reg == n_eff);
    assign slot_ok  = 32'(req.data.slot) < PROCS;
    assign load_w   = WB'(req.data.weight);

    // entry layout: id, weight, remaining
    assign c_r  = mem_rdata[WB-1:0];
    assign c_w  = mem_rdata[2*WB-1:WB];
    assign c_id = mem_rdata[2*WB+ID_W-1:2*WB];

    // exact ratio compare by cross-multiplication
    assign c_live = (c_w != '0) && (c_r != '0);
    assign lhs    = {{WB{1'b0}}, c_r} * {{WB{1'b0}}, best_w_reg};
    assign rhs    = {{WB{1'b0}}, best_r_reg} * {{WB{1'b0}}, c_w};
    assign take   = c_live && (!found_reg || (lhs > rhs));

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        completed_next  = completed_reg;
        scan_cnt_next   = scan_cnt_reg;
        arr_next        = arr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_w_next     = best_w_reg;
        best_r_next     = best_r_reg;
        best_id_next    = best_id_reg;
        res_next        = res_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        mem_ctl         = '0;
        mem_waddr       = best_idx_reg;
        mem_wdata       = {best_id_reg, best_w_reg, best_r_reg - WB'(1)};
        mem_raddr       = IDX_W'(scan_cnt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next = '0;
                    if (req.data.command == CMD_LOAD)
                    begin
                        mem_ctl.wr_en   = slot_ok;
                        mem_waddr       = IDX_W'(req.data.slot);
                        mem_wdata       = {req.data.proc_id, load_w, load_w};
                        tick_count_next = '0;
                        completed_next  = '0;
                        state_next      = S_POST;
                    end
                    else if (is_done)
                    begin
                        res_next.finished = 1'b1;
                        state_next        = S_POST;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr     = '0;
                        scan_cnt_next = ACT_W'(1);
                        arr_next      = '0;
                        found_next    = 1'b0;
                        best_idx_next = '0;
                        // no entry takes part: report an empty tick
                        if (n_eff == '0)
                        begin
                            state_next = S_WB;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // one entry arrives per beat while the next read, if any entry is left, is issued
                if (scan_cnt_reg < n_eff)
                begin
                    mem_ctl.rd_en = 1'b1;
                    scan_cnt_next = scan_cnt_reg + ACT_W'(1);
                end
                arr_next = arr_reg + ACT_W'(1);
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = IDX_W'(arr_reg);
                    best_w_next   = c_w;
                    best_r_next   = c_r;
                    best_id_next  = c_id;
                end
                if (arr_reg == n_eff - ACT_W'(1))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_ctl.wr_en = found_reg;
                if (found_reg && (best_r_reg == WB'(1)))
                begin
                    completed_next = completed_reg + ACT_W'(1);
                end
                res_next.granted    = found_reg;
                res_next.grant_slot = SLOT_W'(best_idx_reg);
                res_next.grant_id   = found_reg ? best_id_reg : '0;
                res_next.tick_time  = tick_count_reg;
                res_next.finished   = 1'b0;
                tick_count_next     = tick_count_reg + TICK_W'(1);
                state_next          = S_POST;
            end
            S_POST:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_count_reg <= '0;
            time_limit_reg   <= '0;
            tick_count_reg   <= '0;
            completed_reg    <= '0;
            scan_cnt_reg     <= '0;
            arr_reg          <= '0;
            found_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            completed_reg  <= completed_next;
            scan_cnt_reg   <= scan_cnt_next;
            arr_reg        <= arr_next;
            found_reg      <= found_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    CFG_ACTIVE_COUNT: active_count_reg <= cfg.data.wdata[ACT_W-1:0];
                    CFG_TIME_LIMIT:   time_limit_reg   <= cfg.data.wdata[TICK_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_w_reg   <= best_w_next;
        best_r_reg   <= best_r_next;
        best_id_reg  <= best_id_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ===== sv/weighted_fair_share_picker_top.sv =====
`timescale 1ns / 1ps
// weighted fair-share picker
// cfg: register writes (index 0 active_count, index 1 time_limit), always ready;
//   write only while the block is idle.
// req: one beat per command. a load writes one table entry and restarts the
//   tick clock; a tick grants one slice to the active entry with the largest
//   remaining/weight ratio, first entry wins a tie.
// rsp: exactly one beat per req beat, in order.
// a tick scans the n active entries through the single read port of the entry
//   memory, one per cycle, with one cross-multiply comparator, then writes the
//   chosen entry back; a tick on a finished block skips the scan.
// the result sits in an output register; req is taken again while it waits,
//   and a further result waits until the receiver takes the earlier one.
// reset clears the control registers, the tick clock and the completion count; the
//   entry memory holds nothing valid until each entry is loaded.
module weighted_fair_share_picker_top #(
    parameter int PROCS       = wfsp_pkg::DEF_PROCS,
    parameter int WEIGHT_BITS = wfsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    wfsp_chan_if.sink    cfg,
    wfsp_chan_if.sink    req,
    wfsp_chan_if.source  rsp
);
    import wfsp_pkg::*;

    localparam int IDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int ENT_W = 2 * WEIGHT_BITS + ID_W;

    mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    wfsp_ctrl #(
        .PROCS       (PROCS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W),
        .ENT_W       (ENT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    wfsp_table #(
        .PROCS (PROCS),
        .IDX_W (IDX_W),
        .ENT_W (ENT_W)
    ) u_table (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== sv/wfsp_checker.sv =====
`timescale 1ns / 1ps

module wfsp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input wfsp_pkg::rsp_beat_t rsp_data
);
    import wfsp_pkg::*;

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp beat changed while stalled");

    // a grant never comes from a finished block
    a_grant_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.granted |-> !rsp_data.finished)
        else $error("granted and finished together");

    // no grant means no slot and no id
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.granted |-> rsp_data.grant_slot == '0 && rsp_data.grant_id == '0)
        else $error("slot or id reported without a grant");

    // a finished beat reports no tick number
    a_finished_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.finished |-> rsp_data.tick_time == '0)
        else $error("finished beat carries a tick number");

endmodule

bind weighted_fair_share_picker_top wfsp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== test/wfsp_share_check.sv =====
`timescale 1ns / 1ps

module wfsp_share_check
    import wfsp_pkg::*;
#(
    parameter int PROCS       = DEF_PROCS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_beat_t cfg_data,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_beat_t req_data,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_beat_t rsp_data,
    output int        errors,
    output int        pending,
    output int        grants,
    output int        finishes,
    output int        starved_ticks
);

    logic [ACT_W-1:0]       act_reg;
    logic [TICK_W-1:0]      limit_reg;
    logic [WEIGHT_BITS-1:0] wgt_tab  [PROCS];
    logic [WEIGHT_BITS-1:0] left_tab [PROCS];
    logic [ID_W-1:0]        id_tab   [PROCS];
    logic [TICK_W-1:0]      tick_clk;
    logic [ACT_W-1:0]       done_cnt;
    rsp_beat_t              due_rsp_q[$];

    // applies one request to the shadow table and returns the result it must produce
    task automatic grant_slice(input req_beat_t b, output rsp_beat_t r);
        int n;
        int best;
        bit found;
        logic [2*WEIGHT_BITS-1:0] lhs;
        logic [2*WEIGHT_BITS-1:0] rhs;

        r = '0;
        n = (act_reg > PROCS) ? PROCS : int'(act_reg);
        if (b.command == CMD_LOAD)
        begin
            if (b.slot < PROCS)
            begin
                wgt_tab[b.slot]  = WEIGHT_BITS'(b.weight);
                left_tab[b.slot] = WEIGHT_BITS'(b.weight);
                id_tab[b.slot]   = b.proc_id;
            end
            tick_clk = '0;
            done_cnt = '0;
        end
        else if (tick_clk >= limit_reg || done_cnt == n)
        begin
            r.finished = 1'b1;
        end
        else
        begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < n; i++)
            begin
                if (wgt_tab[i] != 0 && left_tab[i] != 0)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        best  = i;
                    end
                    else
                    begin
                        // remaining/weight compared by cross-multiplication, strict
                        lhs = left_tab[i] * wgt_tab[best];
                        rhs = left_tab[best] * wgt_tab[i];
                        if (lhs > rhs)
                            best = i;
                    end
                end
            end
            r.tick_time = tick_clk;
            if (found)
            begin
                r.granted    = 1'b1;
                r.grant_slot = SLOT_W'(best);
                r.grant_id   = id_tab[best];
                left_tab[best] = left_tab[best] - 1'b1;
                if (left_tab[best] == 0)
                    done_cnt = done_cnt + 1'b1;
            end
            tick_clk = tick_clk + 1'b1;
        end
    endtask

    task automatic match_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_beat_t want;
        rsp_beat_t fresh;

        if (!rst_n)
        begin
            due_rsp_q.delete();
            act_reg   = '0;
            limit_reg = '0;
            tick_clk  = '0;
            done_cnt  = '0;
            for (int i = 0; i < PROCS; i++)
            begin
                wgt_tab[i]  = '0;
                left_tab[i] = '0;
                id_tab[i]   = '0;
            end
            errors        = 0;
            pending       = 0;
            grants        = 0;
            finishes      = 0;
            starved_ticks = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    CFG_ACTIVE_COUNT: act_reg = cfg_data.wdata[ACT_W-1:0];
                    CFG_TIME_LIMIT:   limit_reg = cfg_data.wdata[TICK_W-1:0];
                    default: ;
                endcase
            end

            // result beat first: it always belongs to an older request
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: result beat with nothing expected, got %p", $time, rsp_data);
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    match_field("granted", want.granted, rsp_data.granted);
                    match_field("grant_slot", want.grant_slot, rsp_data.grant_slot);
                    match_field("grant_id", want.grant_id, rsp_data.grant_id);
                    match_field("tick_time", want.tick_time, rsp_data.tick_time);
                    match_field("finished", want.finished, rsp_data.finished);
                end
            end

            if (req_valid && req_ready)
            begin
                grant_slice(req_data, fresh);
                due_rsp_q.push_back(fresh);
                if (req_data.command == CMD_TICK)
                begin
                    if (fresh.granted)
                        grants = grants + 1;
                    else if (fresh.finished)
                        finishes = finishes + 1;
                    else
                        starved_ticks = starved_ticks + 1;
                end
            end

            pending = due_rsp_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wfsp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 510;

    logic clk;
    logic rst_n;

    wfsp_chan_if #(.T(cfg_beat_t)) cfg_ch ();
    wfsp_chan_if #(.T(req_beat_t)) req_ch ();
    wfsp_chan_if #(.T(rsp_beat_t)) rsp_ch ();

    int errors;
    int pending;
    int grants;
    int finishes;
    int starved_ticks;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int quiet_cycles = 0;
    bit hold_wanted;
    logic [DEF_PROCS-1:0] loaded;
    logic [ACT_W-1:0]     act_now;

    weighted_fair_share_picker_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    wfsp_share_check u_share_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_data      (cfg_ch.data),
        .req_valid     (req_ch.valid),
        .req_ready     (req_ch.ready),
        .req_data      (req_ch.data),
        .rsp_valid     (rsp_ch.valid),
        .rsp_ready     (rsp_ch.ready),
        .rsp_data      (rsp_ch.data),
        .errors        (errors),
        .pending       (pending),
        .grants        (grants),
        .finishes      (finishes),
        .starved_ticks (starved_ticks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : rsp_side
        int hold_left;

        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input req_beat_t b);
        bit took;

        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= b;
        do
        begin
            @(negedge clk);
            took = req_ch.ready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    task automatic load_slot(input int s, input int w, input int id);
        req_beat_t b;

        b.command = CMD_LOAD;
        b.slot    = SLOT_W'(s);
        b.weight  = IN_WGT_W'(w);
        b.proc_id = ID_W'(id);
        loaded[s] = 1'b1;
        send_item(b);
    endtask

    // the other fields of a tick carry random junk
    task automatic tick_once();
        req_beat_t b;

        b.command = CMD_TICK;
        b.slot    = SLOT_W'($urandom());
        b.weight  = IN_WGT_W'($urandom());
        b.proc_id = ID_W'($urandom());
        send_item(b);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        bit took;

        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, wdata: val};
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic configure(input bit do_act, input logic [ACT_W-1:0] act_v,
                             input bit do_lim, input logic [TICK_W-1:0] lim_v);
        drain();
        if (do_act)
        begin
            cfg_beat(CFG_ACTIVE_COUNT, CFG_DAT_W'(act_v));
            act_now = act_v;
        end
        if (do_lim)
            cfg_beat(CFG_TIME_LIMIT, lim_v);
        cfg_ch.valid <= 1'b0;
    endtask

    // one scheduling run: settings, a load of the active entries (at times skipped once all are loaded), then ticks
    task automatic run_round(input bit with_hold);
        int n;
        int w;
        int total;
        int n_ticks;
        int pick;
        int tmp;
        int order [DEF_PROCS];
        int unsigned need;
        bit small_w;
        bit do_act;
        bit do_lim;
        logic [ACT_W-1:0]  act_v;
        logic [TICK_W-1:0] lim_v;

        pick = $urandom_range(99);
        if (pick < 6)
            act_v = '0;
        else if (pick < 10)
            act_v = ACT_W'($urandom_range(DEF_PROCS + 1, 15));
        else
            act_v = ACT_W'($urandom_range(1, DEF_PROCS));
        small_w = ($urandom_range(99) < 70);
        if (small_w)
            lim_v = ($urandom_range(99) < 70) ? 16'hFFFF : TICK_W'($urandom_range(0, 40));
        else if ($urandom_range(99) < 15)
            lim_v = TICK_W'($urandom());
        else
            lim_v = TICK_W'($urandom_range(0, 90));
        do_act = ($urandom_range(9) != 0);
        do_lim = !do_act || ($urandom_range(9) != 0);
        configure(do_act, act_v, do_lim, lim_v);
        if (with_hold)
            hold_wanted = 1'b1;

        n = (act_now > DEF_PROCS) ? DEF_PROCS : int'(act_now);
        need = (1 << n) - 1;
        total = 20;
        // never tick while a scanned entry is still unwritten
        if ((loaded & need) != need || $urandom_range(9) != 0)
        begin
            total = 0;
            for (int i = 0; i < n; i++)
                order[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                pick = $urandom_range(i);
                tmp = order[i];
                order[i] = order[pick];
                order[pick] = tmp;
            end
            for (int i = 0; i < n; i++)
            begin
                if (small_w)
                    w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                else
                    w = $urandom_range(0, 255);
                load_slot(order[i], w, $urandom_range(0, 255));
                total += w;
            end
            if (n < DEF_PROCS && $urandom_range(2) == 0)
                load_slot($urandom_range(n, DEF_PROCS - 1), $urandom_range(0, 255),
                          $urandom_range(0, 255));
        end
        n_ticks = total + $urandom_range(1, 3);
        if (n_ticks > 60)
            n_ticks = 60;
        for (int k = 0; k < n_ticks; k++)
        begin
            // a stray reload restarts the tick clock mid-run
            if ($urandom_range(99) < 6)
                load_slot($urandom_range(0, DEF_PROCS - 1), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            tick_once();
        end
    endtask

    initial
    begin : stimulus
        int target;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        hold_wanted    = 1'b0;
        loaded         = '0;
        act_now        = '0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no active entries after reset, so the block is finished at once
        tick_once();

        // zero weight never picked, then nothing left, then the time limit
        configure(1'b1, 4'd2, 1'b1, 16'd4);
        load_slot(0, 0, 8'hFF);
        load_slot(1, 1, 8'h00);
        repeat (5) tick_once();

        // full table, extreme weights, equal ratios resolve to the first entry
        configure(1'b1, 4'd8, 1'b1, 16'hFFFF);
        load_slot(0, 255, 8'h5A);
        load_slot(1, 3, 8'hA5);
        load_slot(2, 3, 8'h0F);
        load_slot(3, 1, 8'hF0);
        load_slot(4, 128, 8'h33);
        load_slot(5, 2, 8'hCC);
        load_slot(6, 254, 8'h01);
        load_slot(7, 3, 8'h80);
        repeat (4) tick_once();

        // active count above the table size, with a zero time limit first
        configure(1'b1, 4'd12, 1'b1, 16'd0);
        tick_once();
        configure(1'b0, 4'd0, 1'b1, 16'd2);
        load_slot(3, 1, 8'h7E);
        repeat (3) tick_once();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 60;
                end
                1:
                begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 9;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            drain();
            target = items_sent + PHASE_ITEMS;
            run_round(phase == 0);
            while (items_sent < target)
                run_round(1'b0);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d request beats: %0d grants, %0d ticks with no candidate,",
                 items_sent, grants, starved_ticks);
        $display("%0d ticks on a finished table, %0d mismatches", finishes, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/wfsp_pkg.sv
sv/wfsp_chan_if.sv
sv/wfsp_table.sv
sv/wfsp_ctrl.sv
sv/weighted_fair_share_picker_top.sv
sv/wfsp_checker.sv
test/wfsp_share_check.sv
test/tb.sv
